// File: rtl/core/spp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_pkg
// Shared constants, codes and the CORDIC angle table for the spherical
// point projection pipeline.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int TURN_BITS    = 32;   // angles in 2^-32 turn
    localparam int CORDIC_STEPS = 31;
    localparam int NORM_MSB     = 52;   // normalized magnitude in [2^52, 2^53)
    localparam int ISQRT_BITS   = 64;
    localparam int ISQRT_STEPS  = ISQRT_BITS / 2;
    localparam int ANGLE_W      = TURN_BITS + 2;

    localparam logic [14:0] INDEX_MAX    = 15'h7fff;
    localparam logic [15:0] WIDTH_RESET  = 16'd20000;
    localparam logic [15:0] HEIGHT_RESET = 16'd10000;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    // atan(2^-i) in 2^-32 turn, rounded to nearest
    function automatic logic [31:0] cordic_angle(input int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            24:      a = 32'd41;
            25:      a = 32'd20;
            26:      a = 32'd10;
            27:      a = 32'd5;
            28:      a = 32'd3;
            29:      a = 32'd1;
            30:      a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/spp_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_isqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module spp_isqrt (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic [spp_pkg::ISQRT_BITS-1:0]      n_in,
    output logic      [spp_pkg::ISQRT_STEPS-1:0]     root_out
);
    import spp_pkg::*;

    logic [ISQRT_BITS-1:0] n_q [ISQRT_STEPS];
    logic [ISQRT_BITS-1:0] r_q [ISQRT_STEPS];

    for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_step
        localparam logic [ISQRT_BITS-1:0] BIT_J =
            ISQRT_BITS'(1) << (ISQRT_BITS - 2 - 2 * j);
        logic [ISQRT_BITS-1:0] n_src;
        logic [ISQRT_BITS-1:0] r_src;
        logic [ISQRT_BITS:0]   trial;

        if (j == 0) begin : g_first
            assign n_src = n_in;
            assign r_src = '0;
        end else begin : g_next
            assign n_src = n_q[j-1];
            assign r_src = r_q[j-1];
        end

        assign trial = {1'b0, r_src} + {1'b0, BIT_J};

        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, n_src} >= trial) begin
                    n_q[j] <= n_src - trial[ISQRT_BITS-1:0];
                    r_q[j] <= (r_src >> 1) + BIT_J;
                end else begin
                    n_q[j] <= n_src;
                    r_q[j] <= r_src >> 1;
                end
            end
        end
    end

    assign root_out = r_q[ISQRT_STEPS-1][ISQRT_STEPS-1:0];

endmodule
`default_nettype wire

// File: rtl/core/spp_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_cordic
// Pipelined vectoring CORDIC: atan2(ny, dx) in 2^-32 turn. Half-plane fold,
// normalization to [2^52, 2^53), then one rotation per stage.
// ----------------------------------------------------------------------------
module spp_cordic #(
    parameter int W = 57
) (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic signed [W-1:0]                dx_in,
    input  wire logic signed [W-1:0]                ny_in,
    output logic signed [spp_pkg::ANGLE_W-1:0]      angle_out
);
    import spp_pkg::*;

    localparam int MW = $clog2(W);
    localparam int AC = TURN_BITS + 1;
    localparam logic signed [ANGLE_W-1:0] HALF = ANGLE_W'(64'd1 << (TURN_BITS - 1));

    // fold
    logic signed [W-1:0]       dx_f, ny_f;
    logic [W-1:0]              mag_y, m_f;
    logic signed [ANGLE_W-1:0] base_f;

    logic signed [W-1:0]       p1_dx_reg, p1_ny_reg;
    logic [W-1:0]              p1_m_reg;
    logic signed [ANGLE_W-1:0] p1_base_reg;
    logic                      p1_zero_reg;

    logic [MW-1:0]             msb_c;
    logic signed [W-1:0]       p2_dx_reg, p2_ny_reg;
    logic [MW-1:0]             p2_msb_reg;
    logic signed [ANGLE_W-1:0] p2_base_reg;
    logic                      p2_zero_reg;

    logic signed [W-1:0]       dx_q   [CORDIC_STEPS+1];
    logic signed [W-1:0]       ny_q   [CORDIC_STEPS+1];
    logic signed [AC-1:0]      acc_q  [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0] base_q [CORDIC_STEPS+1];
    logic                      zero_q [CORDIC_STEPS+1];

    always_comb begin
        if (dx_in[W-1]) begin
            dx_f   = -dx_in;
            ny_f   = -ny_in;
            base_f = ny_in[W-1] ? -HALF : HALF;
        end else begin
            dx_f   = dx_in;
            ny_f   = ny_in;
            base_f = '0;
        end
        mag_y = ny_f[W-1] ? W'(-ny_f) : W'(ny_f);
        m_f   = (W'(dx_f) > mag_y) ? W'(dx_f) : mag_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_dx_reg   <= dx_f;
            p1_ny_reg   <= ny_f;
            p1_m_reg    <= m_f;
            p1_base_reg <= base_f;
            p1_zero_reg <= (dx_in == '0) && (ny_in == '0);
        end
    end

    always_comb begin
        msb_c = '0;
        for (int i = 0; i < W; i++) begin
            if (p1_m_reg[i]) msb_c = MW'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_dx_reg   <= p1_dx_reg;
            p2_ny_reg   <= p1_ny_reg;
            p2_msb_reg  <= msb_c;
            p2_base_reg <= p1_base_reg;
            p2_zero_reg <= p1_zero_reg;
        end
    end

    // normalize
    always_ff @(posedge aclk) begin
        if (en) begin
            if (p2_msb_reg > MW'(NORM_MSB)) begin
                dx_q[0] <= p2_dx_reg >>> (p2_msb_reg - MW'(NORM_MSB));
                ny_q[0] <= p2_ny_reg >>> (p2_msb_reg - MW'(NORM_MSB));
            end else begin
                dx_q[0] <= p2_dx_reg <<< (MW'(NORM_MSB) - p2_msb_reg);
                ny_q[0] <= p2_ny_reg <<< (MW'(NORM_MSB) - p2_msb_reg);
            end
            acc_q[0]  <= '0;
            base_q[0] <= p2_base_reg;
            zero_q[0] <= p2_zero_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        localparam logic signed [AC-1:0] ANG = $signed({1'b0, cordic_angle(i)});
        logic signed [W-1:0] sx, sy;

        assign sx = dx_q[i] >>> i;
        assign sy = ny_q[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!ny_q[i][W-1]) begin
                    dx_q[i+1]  <= dx_q[i] + sy;
                    ny_q[i+1]  <= ny_q[i] - sx;
                    acc_q[i+1] <= acc_q[i] + ANG;
                end else begin
                    dx_q[i+1]  <= dx_q[i] - sy;
                    ny_q[i+1]  <= ny_q[i] + sx;
                    acc_q[i+1] <= acc_q[i] - ANG;
                end
                base_q[i+1] <= base_q[i];
                zero_q[i+1] <= zero_q[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_out <= zero_q[CORDIC_STEPS] ? '0 :
                         base_q[CORDIC_STEPS] + ANGLE_W'(acc_q[CORDIC_STEPS]);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/spherical_point_projection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spherical_point_projection
// Projects a Cartesian point onto a range image: column from azimuth,
// row from polar angle, intensity passed along, origin flagged invalid.
//
//   port group  dir  handshake          word
//   s_*         in   s_valid/s_ready    x, y, z, intensity
//   m_*         out  m_valid/m_ready    column, row, intensity, point flag
//   cfg_*       in   cfg_wr_en          image width / height
//
// One word per cycle sustained while the skid is empty. From input accept to
// m_valid a word passes the 32-stage square root, then the 35-stage CORDIC.
// All stages advance together; a one-word skid behind the output register
// holds a word while m_ready is low, and s_ready drops only when it is full.
// Reset clears valid bits and loads width 20000, height 10000.
// ----------------------------------------------------------------------------
module spherical_point_projection #(
    parameter int COORD_BITS = 24,
    parameter int ANGLE_BITS = 20
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_x_coord,
    input  wire logic signed [COORD_BITS-1:0] s_y_coord,
    input  wire logic signed [COORD_BITS-1:0] s_z_coord,
    input  wire logic [15:0]                  s_intensity_in,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [14:0]                       m_col_index,
    output logic [14:0]                       m_row_index,
    output logic [15:0]                       m_intensity_out,
    output logic                              m_point_valid,
    input  wire logic                         cfg_wr_en,
    input  wire logic [0:0]                   cfg_addr,
    input  wire logic [15:0]                  cfg_wdata
);
    import spp_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int SQW = 2 * CB;
    localparam int SW  = SQW + 1;
    localparam int CW  = (CB + 33 > 56) ? CB + 33 : 56;
    localparam int QW  = ANGLE_BITS + 1;
    localparam int PW  = QW + 16;
    localparam int TW  = 5;

    localparam int IX_T       = 3;
    localparam int IX_ISQ_OUT = 4 + ISQRT_STEPS;
    localparam int IX_CRD_OUT = IX_ISQ_OUT + 1 + CORDIC_STEPS + 4;
    localparam int NSIDE      = IX_CRD_OUT + 4;

    localparam logic signed [ANGLE_W:0] HALF_W = (ANGLE_W+1)'(64'd1 << (TURN_BITS - 1));
    localparam logic signed [ANGLE_W:0] FULL_W = (ANGLE_W+1)'(64'd1 << TURN_BITS);

    typedef struct packed {
        logic                  nz;
        logic signed [CB-1:0]  x;
        logic signed [CB-1:0]  y;
        logic signed [CB-1:0]  z;
        logic [TW-1:0]         t;
        logic [15:0]           inten;
    } side_t;

    typedef struct packed {
        logic [14:0] col;
        logic [14:0] row;
        logic [15:0] inten;
        logic        pv;
    } out_t;

    function automatic logic [14:0] clamp_index(input logic [17:0] v, input logic [15:0] n);
        logic [17:0] lim;
        logic [17:0] r;
        lim = 18'(n) - 18'd1;
        r   = v;
        if (r > lim) r = lim;
        if (r > 18'(INDEX_MAX)) r = 18'(INDEX_MAX);
        if (n == 16'd0) r = '0;
        return r[14:0];
    endfunction

    logic                 en;
    logic [15:0]          width_reg, height_reg;
    logic [NSIDE-1:0]     vld_reg;
    side_t                side_reg [NSIDE];
    side_t                side_in;
    side_t                side_scaled;

    logic [CB-1:0]        ax, ay;
    logic [SQW-1:0]       sq_x_reg, sq_y_reg;
    logic [SW-1:0]        sum_reg, s3_reg;
    logic [TW-1:0]        t_next;
    logic [ISQRT_BITS-1:0] n_reg;
    logic [ISQRT_STEPS-1:0] root;

    logic signed [CW-1:0] el_dx_reg, el_ny_reg, az_dx_reg, az_ny_reg;
    logic signed [ANGLE_W-1:0] az_angle, el_angle;
    logic signed [ANGLE_W:0]   az_sum, el_ext;
    logic [TURN_BITS:0]   az_cl, el_cl;
    logic [QW-1:0]        qa_reg, qe_reg;
    logic [PW-1:0]        pa_reg, pe_reg;
    logic [14:0]          col_reg, row_reg;

    out_t                 pipe_out, m_data_reg, skid_data_reg;
    logic                 m_valid_reg, skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid and side-band line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSIDE-2:0], s_valid};
        end
    end

    always_comb begin
        side_in.nz    = (s_x_coord != '0) || (s_y_coord != '0) || (s_z_coord != '0);
        side_in.x     = s_x_coord;
        side_in.y     = s_y_coord;
        side_in.z     = s_z_coord;
        side_in.t     = '0;
        side_in.inten = s_intensity_in;
    end

    always_comb begin
        side_scaled   = side_reg[IX_T-1];
        side_scaled.t = t_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NSIDE; k++) begin
                if (k == IX_T) begin
                    side_reg[k] <= side_scaled;
                end else begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // squares, sum, scale exponent, scaled sum
    assign ax = side_reg[0].x[CB-1] ? CB'(-side_reg[0].x) : CB'(side_reg[0].x);
    assign ay = side_reg[0].y[CB-1] ? CB'(-side_reg[0].y) : CB'(side_reg[0].y);

    always_comb begin
        int p;
        p = 0;
        for (int i = 0; i < SW; i++) begin
            if (sum_reg[i]) p = i;
        end
        t_next = (sum_reg == '0) ? '0 : TW'((63 - p) >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg <= SQW'(ax) * SQW'(ax);
            sq_y_reg <= SQW'(ay) * SQW'(ay);
            sum_reg  <= SW'(sq_x_reg) + SW'(sq_y_reg);
            s3_reg   <= sum_reg;
            n_reg    <= ISQRT_BITS'(s3_reg) << {side_reg[IX_T].t, 1'b0};
        end
    end

    spp_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .n_in     (n_reg),
        .root_out (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            el_dx_reg <= CW'(side_reg[IX_ISQ_OUT].z) <<< side_reg[IX_ISQ_OUT].t;
            el_ny_reg <= $signed(CW'(root));
            az_dx_reg <= CW'(side_reg[IX_ISQ_OUT].x);
            az_ny_reg <= CW'(side_reg[IX_ISQ_OUT].y);
        end
    end

    spp_cordic #(.W(CW)) u_cordic_az (
        .aclk      (aclk),
        .en        (en),
        .dx_in     (az_dx_reg),
        .ny_in     (az_ny_reg),
        .angle_out (az_angle)
    );

    spp_cordic #(.W(CW)) u_cordic_el (
        .aclk      (aclk),
        .en        (en),
        .dx_in     (el_dx_reg),
        .ny_in     (el_ny_reg),
        .angle_out (el_angle)
    );

    // angle clamp and truncation
    always_comb begin
        az_sum = (ANGLE_W+1)'(az_angle) + HALF_W;
        el_ext = (ANGLE_W+1)'(el_angle);
        if (az_sum[ANGLE_W]) begin
            az_cl = '0;
        end else if (az_sum > FULL_W) begin
            az_cl = FULL_W[TURN_BITS:0];
        end else begin
            az_cl = az_sum[TURN_BITS:0];
        end
        if (el_ext[ANGLE_W]) begin
            el_cl = '0;
        end else if (el_ext > HALF_W) begin
            el_cl = HALF_W[TURN_BITS:0];
        end else begin
            el_cl = el_ext[TURN_BITS:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qa_reg  <= az_cl[TURN_BITS -: QW];
            qe_reg  <= el_cl[TURN_BITS -: QW];
            pa_reg  <= PW'(qa_reg) * PW'(width_reg);
            pe_reg  <= PW'(qe_reg) * PW'(height_reg);
            col_reg <= clamp_index(18'(pa_reg[PW-1:ANGLE_BITS]), width_reg);
            row_reg <= clamp_index(18'(pe_reg[PW-1:ANGLE_BITS-1]), height_reg);
        end
    end

    always_comb begin
        pipe_out.pv    = side_reg[NSIDE-1].nz;
        pipe_out.col   = side_reg[NSIDE-1].nz ? col_reg : '0;
        pipe_out.row   = side_reg[NSIDE-1].nz ? row_reg : '0;
        pipe_out.inten = side_reg[NSIDE-1].inten;
    end

    // output register and skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (vld_reg[NSIDE-1]) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (vld_reg[NSIDE-1]) begin
            if (!m_valid_reg || m_ready) begin
                m_data_reg <= pipe_out;
            end else begin
                skid_data_reg <= pipe_out;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_col_index     = m_data_reg.col;
    assign m_row_index     = m_data_reg.row;
    assign m_intensity_out = m_data_reg.inten;
    assign m_point_valid   = m_data_reg.pv;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a word while output register is empty");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_origin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_point_valid) |-> (m_col_index == '0 && m_row_index == '0))
        else $error("origin point with nonzero indices");

    a_col_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && width_reg != 16'd0) |-> (16'(m_col_index) < width_reg))
        else $error("column beyond image width");
`endif

endmodule
`default_nettype wire
